[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/v3alu_pkg.sv]
// Shared widths, operation codes and helpers of the vector unit.
package v3alu_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int OPND_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int LEN_W      = 2 * DATA_W;
  localparam int QUO_W      = 2 * FRAC_BITS + 3;
  localparam int DIV_STEPS  = QUO_W;
  localparam int ROOT_W     = LEN_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int LAT        = DIV_STEPS + SQRT_STEPS;

  localparam logic signed [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    KIND_NORM  = 3'd0,
    KIND_DOT   = 3'd1,
    KIND_CROSS = 3'd2,
    KIND_DIST  = 3'd3,
    KIND_NEG   = 3'd4
  } kind_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } clamp_t;

  // Control and early results that ride alongside the divider and root lanes.
  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] res_x;
    logic signed [DATA_W-1:0] res_y;
    logic signed [DATA_W-1:0] res_z;
    logic signed [DATA_W-1:0] scalar;
    logic                     sat;
    logic [2:0]               neg;
    logic                     zero;
    logic                     big;
    logic [LEN_W-1:0]         dsum;
  } ctl_t;

  // Round a sum with 2*FRAC_BITS fraction bits, half up, and clamp.
  function automatic clamp_t round_clamp(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] r;
    clamp_t                  c;
    r = (s + SUM_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > SUM_W'(FX_MAX)) begin
      c.val = FX_MAX;
      c.sat = 1'b1;
    end else if (r < SUM_W'(FX_MIN)) begin
      c.val = FX_MIN;
      c.sat = 1'b1;
    end else begin
      c.val = DATA_W'(r);
      c.sat = 1'b0;
    end
    return c;
  endfunction

  function automatic clamp_t negate_clamp(input logic signed [DATA_W-1:0] v);
    clamp_t c;
    if (v == FX_MIN) begin
      c.val = FX_MAX;
      c.sat = 1'b1;
    end else begin
      c.val = -v;
      c.sat = 1'b0;
    end
    return c;
  endfunction

endpackage

[design/v3alu_udiv.sv]
// Pipelined restoring divider: quo = floor(num * 2^(QUO_W-1) / den), one bit per stage.
module v3alu_udiv import v3alu_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [LEN_W-1:0] num,
  input  logic [LEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [LEN_W-1:0] rm [DIV_STEPS-1];
  logic [LEN_W-1:0] dn [DIV_STEPS-1];
  logic [QUO_W-1:0] qt [DIV_STEPS];

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_stage
      if (k == 0) begin : g_first
        logic q0;
        assign q0 = (num >= den);
        always_ff @(posedge clk) begin
          if (en) begin
            rm[0] <= q0 ? (num - den) : num;
            dn[0] <= den;
            qt[0] <= QUO_W'(q0);
          end
        end
      end else begin : g_step
        logic [LEN_W:0] r2;
        logic [LEN_W:0] d2;
        logic           bit_q;
        assign r2    = {rm[k-1], 1'b0};
        assign d2    = {1'b0, dn[k-1]};
        assign bit_q = (r2 >= d2);
        always_ff @(posedge clk) begin
          if (en) begin
            qt[k] <= {qt[k-1][QUO_W-2:0], bit_q};
          end
        end
        if (k < DIV_STEPS - 1) begin : g_carry
          always_ff @(posedge clk) begin
            if (en) begin
              rm[k] <= bit_q ? LEN_W'(r2 - d2) : LEN_W'(r2);
              dn[k] <= dn[k-1];
            end
          end
        end
      end
    end
  endgenerate

  assign quo = qt[DIV_STEPS-1];

endmodule

[design/v3alu_isqrt.sv]
// Pipelined digit-by-digit integer square root with exact remainder, one bit per stage.
module v3alu_isqrt import v3alu_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [LEN_W-1:0]  x,
  output logic [ROOT_W-1:0] root,
  output logic [REM_W-1:0]  rem
);

  logic [LEN_W-1:0]  xs [SQRT_STEPS-1];
  logic [ROOT_W-1:0] rt [SQRT_STEPS];
  logic [REM_W-1:0]  rm [SQRT_STEPS];

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_stage
      logic [LEN_W-1:0]  x_in;
      logic [ROOT_W-1:0] r_in;
      logic [REM_W-1:0]  m_in;
      logic [REM_W+1:0]  t_rem;
      logic [REM_W+1:0]  trial;
      logic              take;

      if (k == 0) begin : g_first
        assign x_in = x;
        assign r_in = '0;
        assign m_in = '0;
      end else begin : g_next
        assign x_in = xs[k-1];
        assign r_in = rt[k-1];
        assign m_in = rm[k-1];
      end

      assign t_rem = {m_in, x_in[LEN_W-1 -: 2]};
      assign trial = (REM_W+2)'({r_in, 2'b01});
      assign take  = (t_rem >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rm[k] <= take ? REM_W'(t_rem - trial) : REM_W'(t_rem);
          rt[k] <= {r_in[ROOT_W-2:0], take};
        end
      end

      if (k < SQRT_STEPS - 1) begin : g_shift
        always_ff @(posedge clk) begin
          if (en) begin
            xs[k] <= x_in << 2;
          end
        end
      end
    end
  endgenerate

  assign root = rt[SQRT_STEPS-1];
  assign rem  = rm[SQRT_STEPS-1];

endmodule

[design/vector3_alu_core.sv]
// Top level of the three-component fixed-point vector unit.
// Takes one item per cycle and returns one result per item, in order, through 4 front stages
// (operand select, multiply, sum and round), 35 divider stages, 32 square-root stages and one
// output register. The depth is set by the 35-bit restoring divider and the 32-bit square root
// that normalize and distance run through; every item travels the full depth. Back-pressure
// on the output stalls the whole pipeline.
module vector3_alu_core import v3alu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               kind,
  input  logic signed [DATA_W-1:0] a_x,
  input  logic signed [DATA_W-1:0] a_y,
  input  logic signed [DATA_W-1:0] a_z,
  input  logic signed [DATA_W-1:0] b_x,
  input  logic signed [DATA_W-1:0] b_y,
  input  logic signed [DATA_W-1:0] b_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] res_x,
  output logic signed [DATA_W-1:0] res_y,
  output logic signed [DATA_W-1:0] res_z,
  output logic signed [DATA_W-1:0] scalar,
  output logic                     saturated
);

  localparam int NST = 4 + LAT;

  logic           adv;
  logic [NST-1:0] vld;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // Stage 1: pick multiplier operands by operation.
  logic signed [OPND_W-1:0] dx, dy, dz;
  logic signed [OPND_W-1:0] ax, ay, az, bx, by, bz;
  logic signed [OPND_W-1:0] opa_next [6];
  logic signed [OPND_W-1:0] opb_next [6];
  logic signed [OPND_W-1:0] opa [6];
  logic signed [OPND_W-1:0] opb [6];
  logic                     big_next;
  logic [2:0]               kind1;
  logic signed [DATA_W-1:0] b1 [3];
  logic                     big1;

  assign ax = OPND_W'(a_x);
  assign ay = OPND_W'(a_y);
  assign az = OPND_W'(a_z);
  assign bx = OPND_W'(b_x);
  assign by = OPND_W'(b_y);
  assign bz = OPND_W'(b_z);
  assign dx = ax - bx;
  assign dy = ay - by;
  assign dz = az - bz;

  function automatic logic too_far(input logic signed [OPND_W-1:0] d);
    return (d > OPND_W'(FX_MAX)) || (d < -OPND_W'(FX_MAX));
  endfunction

  assign big_next = too_far(dx) || too_far(dy) || too_far(dz);

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      opa_next[i] = '0;
      opb_next[i] = '0;
    end
    case (kind)
      KIND_NORM: begin
        opa_next[0] = bx; opb_next[0] = bx;
        opa_next[1] = by; opb_next[1] = by;
        opa_next[2] = bz; opb_next[2] = bz;
      end
      KIND_DOT: begin
        opa_next[0] = ax; opb_next[0] = bx;
        opa_next[1] = ay; opb_next[1] = by;
        opa_next[2] = az; opb_next[2] = bz;
      end
      KIND_CROSS: begin
        opa_next[0] = ay; opb_next[0] = bz;
        opa_next[1] = az; opb_next[1] = by;
        opa_next[2] = az; opb_next[2] = bx;
        opa_next[3] = ax; opb_next[3] = bz;
        opa_next[4] = ax; opb_next[4] = by;
        opa_next[5] = ay; opb_next[5] = bx;
      end
      KIND_DIST: begin
        opa_next[0] = dx; opb_next[0] = dx;
        opa_next[1] = dy; opb_next[1] = dy;
        opa_next[2] = dz; opb_next[2] = dz;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        opa[i] <= opa_next[i];
        opb[i] <= opb_next[i];
      end
      kind1 <= kind;
      b1[0] <= b_x;
      b1[1] <= b_y;
      b1[2] <= b_z;
      big1  <= big_next;
    end
  end

  // Stage 2: products.
  logic signed [PROD_W-1:0] prod [6];
  logic [2:0]               kind2;
  logic signed [DATA_W-1:0] b2 [3];
  logic                     big2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        prod[i] <= opa[i] * opb[i];
      end
      kind2 <= kind1;
      b2    <= b1;
      big2  <= big1;
    end
  end

  // Stage 3: sums and differences.
  logic signed [SUM_W-1:0]  sum3;
  logic signed [SUM_W-1:0]  crs3 [3];
  logic [LEN_W-1:0]         num3 [3];
  logic [2:0]               kind3;
  logic signed [DATA_W-1:0] b3 [3];
  logic                     big3;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum3    <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
      crs3[0] <= SUM_W'(prod[0]) - SUM_W'(prod[1]);
      crs3[1] <= SUM_W'(prod[2]) - SUM_W'(prod[3]);
      crs3[2] <= SUM_W'(prod[4]) - SUM_W'(prod[5]);
      for (int i = 0; i < 3; i++) begin
        num3[i] <= LEN_W'(prod[i]);
      end
      kind3 <= kind2;
      b3    <= b2;
      big3  <= big2;
    end
  end

  // Stage 4: round and clamp the short operations, launch the long ones.
  ctl_t             ctl_next;
  ctl_t             ctl4;
  logic [LEN_W-1:0] num4 [3];
  logic [LEN_W-1:0] den4;
  clamp_t           rc_dot;
  clamp_t           rc_crs [3];
  clamp_t           rc_neg [3];

  always_comb begin
    rc_dot = round_clamp(sum3);
    for (int i = 0; i < 3; i++) begin
      rc_crs[i] = round_clamp(crs3[i]);
      rc_neg[i] = negate_clamp(b3[i]);
    end
    ctl_next.kind   = kind3;
    ctl_next.res_x  = '0;
    ctl_next.res_y  = '0;
    ctl_next.res_z  = '0;
    ctl_next.scalar = '0;
    ctl_next.sat    = 1'b0;
    ctl_next.neg    = {b3[2][DATA_W-1], b3[1][DATA_W-1], b3[0][DATA_W-1]};
    ctl_next.zero   = (sum3[LEN_W-1:0] == '0);
    ctl_next.big    = big3;
    ctl_next.dsum   = sum3[LEN_W-1:0];
    case (kind3)
      KIND_NORM: begin
        // zero length hands B back unchanged
        ctl_next.res_x = b3[0];
        ctl_next.res_y = b3[1];
        ctl_next.res_z = b3[2];
      end
      KIND_DOT: begin
        ctl_next.scalar = rc_dot.val;
        ctl_next.sat    = rc_dot.sat;
      end
      KIND_CROSS: begin
        ctl_next.res_x = rc_crs[0].val;
        ctl_next.res_y = rc_crs[1].val;
        ctl_next.res_z = rc_crs[2].val;
        ctl_next.sat   = rc_crs[0].sat || rc_crs[1].sat || rc_crs[2].sat;
      end
      KIND_NEG: begin
        ctl_next.res_x = rc_neg[0].val;
        ctl_next.res_y = rc_neg[1].val;
        ctl_next.res_z = rc_neg[2].val;
        ctl_next.sat   = rc_neg[0].sat || rc_neg[1].sat || rc_neg[2].sat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl4 <= ctl_next;
      num4 <= num3;
      den4 <= sum3[LEN_W-1:0];
    end
  end

  // Side line that keeps control aligned with the divider and root lanes.
  ctl_t line [LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      line[0] <= ctl4;
      for (int k = 1; k < LAT; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  // Long lanes: divide each squared component by the squared length, then root.
  logic [QUO_W-1:0]  quo [3];
  logic [LEN_W-1:0]  sq_in [3];
  logic [ROOT_W-1:0] root [3];
  logic [REM_W-1:0]  rem [3];

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      v3alu_udiv u_div (
        .clk (clk),
        .en  (adv),
        .num (num4[g]),
        .den (den4),
        .quo (quo[g])
      );

      if (g == 0) begin : g_share
        // lane 0 also takes the distance sum
        assign sq_in[g] = (line[DIV_STEPS-1].kind == KIND_DIST) ?
                          line[DIV_STEPS-1].dsum : LEN_W'(quo[g]);
      end else begin : g_plain
        assign sq_in[g] = LEN_W'(quo[g]);
      end

      v3alu_isqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .x    (sq_in[g]),
        .root (root[g]),
        .rem  (rem[g])
      );
    end
  endgenerate

  // Finish: round the roots and merge.
  ctl_t                     fin;
  logic signed [DATA_W-1:0] unit_c [3];
  logic [ROOT_W:0]          dist_r;
  logic signed [DATA_W-1:0] fin_res [3];

  always_comb begin
    fin = line[LAT-1];
    for (int i = 0; i < 3; i++) begin
      unit_c[i] = DATA_W'(((ROOT_W+1)'(root[i]) + (ROOT_W+1)'(1)) >> 1);
    end
    dist_r = (rem[0] > REM_W'(root[0])) ? (ROOT_W+1)'(root[0]) + (ROOT_W+1)'(1) :
                                           (ROOT_W+1)'(root[0]);
    fin_res[0] = fin.res_x;
    fin_res[1] = fin.res_y;
    fin_res[2] = fin.res_z;
    case (fin.kind)
      KIND_NORM: begin
        if (!fin.zero) begin
          for (int i = 0; i < 3; i++) begin
            fin_res[i] = fin.neg[i] ? -unit_c[i] : unit_c[i];
          end
        end
      end
      KIND_DIST: begin
        if (fin.big || dist_r > (ROOT_W+1)'(FX_MAX)) begin
          fin.scalar = FX_MAX;
          fin.sat    = 1'b1;
        end else begin
          fin.scalar = DATA_W'(dist_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_x     <= fin_res[0];
      res_y     <= fin_res[1];
      res_z     <= fin_res[2];
      scalar    <= fin.scalar;
      saturated <= fin.sat;
    end
  end

endmodule

[design/v3alu_checker.sv]
// Port-level checks on the vector unit, bound to the top level.
`include "assert_macros.svh"

module v3alu_props import v3alu_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] res_x,
  input logic signed [DATA_W-1:0] res_y,
  input logic signed [DATA_W-1:0] res_z,
  input logic signed [DATA_W-1:0] scalar,
  input logic                     saturated
);

  logic                stall;
  logic [4*DATA_W:0]   res_all;
  logic                at_edge;

  assign stall   = out_valid && !out_ready;
  assign res_all = {res_x, res_y, res_z, scalar, saturated};
  assign at_edge = (scalar == FX_MAX) || (scalar == FX_MIN) ||
                   (res_x == FX_MAX) || (res_x == FX_MIN) ||
                   (res_y == FX_MAX) || (res_y == FX_MIN) ||
                   (res_z == FX_MAX) || (res_z == FX_MIN);

  // a stalled result holds its payload
  `ASSERT_CLK(a_out_hold, stall |=> $stable(res_all), "result changed while stalled")

  // an empty or draining output never blocks the input
  `ASSERT_CLK(a_ready_free, !stall |-> in_ready, "input blocked with output free")

  `ASSERT_CLK_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result shown right after reset")

  // a clamp leaves some field at a range end
  `ASSERT_CLK(a_sat_edge, out_valid && saturated |-> at_edge, "saturated without a clamped field")

endmodule

bind vector3_alu_core v3alu_props u_v3alu_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .res_x     (res_x),
  .res_y     (res_y),
  .res_z     (res_z),
  .scalar    (scalar),
  .saturated (saturated)
);
